// ===== design/bpa_pkg.sv =====
// shared types and constants of the bitmap page allocator
package bpa_pkg;

  localparam int CMD_W         = 2;
  localparam int PAGE_W        = 12;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 13;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 32;
  localparam int WORD_W        = 64;
  localparam int WORD_SH       = 6;
  localparam int QUEUE_DEPTH   = 2;
  localparam int DEF_NUM_PAGES = 4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_CHECK = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_BEYOND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_RMW   = 2'd2,
    S_SCAN  = 2'd3
  } state_t;

  // classified request handed from front to back
  typedef struct packed {
    cmd_t              cmd;
    logic [PAGE_W-1:0] page;
    logic              in_range;
    logic              nonzero;
  } req_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

// ===== design/bpa_ram.sv =====
// generic simple dual-port ram with registered read
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bpa_front.sv =====
// front stage: takes requests, decodes the command and range-checks the page
module bpa_front #(
  parameter int NUM_PAGES = bpa_pkg::DEF_NUM_PAGES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bpa_pkg::IN_DATA_W-1:0]  in_tdata,
  input  bpa_pkg::back_stat_t            back_stat,
  input  logic                           q_ready,
  output logic                           q_push,
  output bpa_pkg::req_t                  q_req
);
  import bpa_pkg::*;

  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam int XW = (CW > PAGE_W) ? CW : PAGE_W + 1;

  logic              fr_valid_r, fr_valid_nxt;
  req_t              fr_req_r, fr_req_nxt;
  logic              in_acc;
  logic [PAGE_W-1:0] in_page;

  assign in_tready = !back_stat.clearing && (!fr_valid_r || q_ready);
  assign in_acc    = in_tvalid && in_tready;
  assign in_page   = in_tdata[CMD_W +: PAGE_W];

  always_comb begin
    fr_req_nxt          = fr_req_r;
    fr_valid_nxt        = fr_valid_r && !q_ready;
    if (in_acc) begin
      fr_valid_nxt        = 1'b1;
      fr_req_nxt.cmd      = cmd_t'(in_tdata[CMD_W-1:0]);
      fr_req_nxt.page     = in_page;
      fr_req_nxt.in_range = XW'(in_page) < XW'(NUM_PAGES);
      fr_req_nxt.nonzero  = in_page != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_req_r <= fr_req_nxt;
  end

  assign q_push = fr_valid_r;
  assign q_req  = fr_req_r;

endmodule

// ===== design/bpa_queue.sv =====
// short request queue between front and back
module bpa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  bpa_pkg::req_t push_req,
  output logic          pop_valid,
  input  logic          pop_ready,
  output bpa_pkg::req_t pop_req
);
  import bpa_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  req_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          push_fire, pop_fire;

  assign push_ready = cnt_r != NW'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_req    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push_fire && !pop_fire) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop_fire && !push_fire) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

// ===== design/bpa_back.sv =====
// back stage: owns the bitmap ram and high-water count and executes requests
module bpa_back #(
  parameter int NUM_PAGES = bpa_pkg::DEF_NUM_PAGES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  bpa_pkg::req_t                  q_req,
  output bpa_pkg::back_stat_t            back_stat,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bpa_pkg::OUT_DATA_W-1:0] out_tdata
);
  import bpa_pkg::*;

  localparam int CW        = $clog2(NUM_PAGES + 1);
  localparam int XW        = (CW > PAGE_W) ? CW : PAGE_W + 1;
  localparam int MAP_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int TAIL      = NUM_PAGES % WORD_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
  // pages past the end of the map in the last word read as used
  localparam logic [WORD_W-1:0] PAD_MASK =
    (TAIL == 0) ? '0 : ~((WORD_W'(1) << TAIL) - WORD_W'(1));
  localparam logic [WORD_W-1:0] RESET_WORD0 = WORD_W'(3);

  typedef struct packed {
    logic               found;
    logic [WORD_SH-1:0] idx;
  } zf_t;

  function automatic zf_t first_zero(input logic [WORD_W-1:0] w);
    zf_t z;
    z.found = 1'b0;
    z.idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        z.found = 1'b1;
        z.idx   = WORD_SH'(i);
      end
    end
    return z;
  endfunction

  state_t             state_r, state_nxt;
  logic [CW-1:0]      hw_r, hw_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]      chk_addr_r, chk_addr_nxt;
  req_t               op_req_r, op_req_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0]  res_page_r, res_page_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [COUNT_W-1:0] res_count_r, res_count_nxt;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  logic [XW-1:0]      q_pg_ext, op_pg_ext;
  logic               q_below_hw;
  logic [AW-1:0]      q_word, op_word;
  logic [WORD_W-1:0]  bit_mask, scan_word;
  zf_t                zf;
  logic [AW+WORD_SH-1:0] alloc_full;
  logic [CW-1:0]      alloc_pg;

  assign q_pop      = (state_r == S_IDLE) && q_valid && (!out_valid_r || out_tready);
  assign q_pg_ext   = XW'(q_req.page);
  assign op_pg_ext  = XW'(op_req_r.page);
  assign q_below_hw = q_pg_ext < XW'(hw_r);
  assign q_word     = q_pg_ext[WORD_SH +: AW];
  assign op_word    = op_pg_ext[WORD_SH +: AW];
  assign bit_mask   = WORD_W'(1) << op_req_r.page[WORD_SH-1:0];
  assign scan_word  = ram_rdata | ((chk_addr_r == LAST_WORD) ? PAD_MASK : '0);
  assign zf         = first_zero(scan_word);
  assign alloc_full = {chk_addr_r, zf.idx};
  assign alloc_pg   = CW'(alloc_full);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_pop) begin
          case (q_req.cmd)
            CMD_ALLOC: state_nxt = S_SCAN;
            CMD_FREE: begin
              if (q_req.in_range && q_req.nonzero) begin
                state_nxt = S_RMW;
              end
            end
            CMD_MARK: begin
              if (q_req.in_range && !q_below_hw) begin
                state_nxt = S_RMW;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RMW: state_nxt = S_IDLE;
      S_SCAN: begin
        if (zf.found || chk_addr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    hw_nxt         = hw_r;
    clr_addr_nxt   = clr_addr_r;
    chk_addr_nxt   = chk_addr_r;
    op_req_nxt     = op_req_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    res_page_nxt   = res_page_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = (clr_addr_r == '0) ? RESET_WORD0 : '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      S_IDLE: begin
        if (q_pop) begin
          op_req_nxt   = q_req;
          res_page_nxt = q_req.page;
          case (q_req.cmd)
            CMD_ALLOC: begin
              ram_re       = 1'b1;
              ram_raddr    = '0;
              chk_addr_nxt = '0;
            end
            CMD_FREE: begin
              if (q_req.in_range && q_req.nonzero) begin
                ram_re    = 1'b1;
                ram_raddr = q_word;
              end else begin
                out_valid_nxt  = 1'b1;
                res_status_nxt = ST_RANGE;
                res_count_nxt  = COUNT_W'(hw_r);
              end
            end
            CMD_MARK: begin
              if (!q_req.in_range) begin
                out_valid_nxt  = 1'b1;
                res_status_nxt = ST_RANGE;
                res_count_nxt  = COUNT_W'(hw_r);
              end else if (q_below_hw) begin
                out_valid_nxt  = 1'b1;
                res_status_nxt = ST_OK;
                res_count_nxt  = COUNT_W'(hw_r);
              end else begin
                ram_re    = 1'b1;
                ram_raddr = q_word;
                hw_nxt    = CW'(q_pg_ext + XW'(1));
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              res_status_nxt = q_below_hw ? ST_OK : ST_BEYOND;
              res_count_nxt  = COUNT_W'(hw_r);
            end
          endcase
        end
      end
      S_RMW: begin
        ram_we         = 1'b1;
        ram_waddr      = op_word;
        ram_wdata      = (op_req_r.cmd == CMD_FREE) ? (ram_rdata & ~bit_mask)
                                                    : (ram_rdata | bit_mask);
        out_valid_nxt  = 1'b1;
        res_status_nxt = ST_OK;
        res_count_nxt  = COUNT_W'(hw_r);
      end
      S_SCAN: begin
        if (zf.found) begin
          ram_we    = 1'b1;
          ram_waddr = chk_addr_r;
          ram_wdata = ram_rdata | (WORD_W'(1) << zf.idx);
          if (alloc_pg >= hw_r) begin
            hw_nxt = alloc_pg + CW'(1);
          end
          out_valid_nxt  = 1'b1;
          res_page_nxt   = PAGE_W'(alloc_full);
          res_status_nxt = ST_OK;
          res_count_nxt  = COUNT_W'((alloc_pg >= hw_r) ? alloc_pg + CW'(1) : hw_r);
        end else if (chk_addr_r == LAST_WORD) begin
          out_valid_nxt  = 1'b1;
          res_page_nxt   = '0;
          res_status_nxt = ST_FULL;
          res_count_nxt  = COUNT_W'(hw_r);
        end else begin
          // next word read overlaps the check of this one
          ram_re       = 1'b1;
          ram_raddr    = chk_addr_r + AW'(1);
          chk_addr_nxt = chk_addr_r + AW'(1);
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_tready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      hw_r        <= CW'(2);
      clr_addr_r  <= '0;
      chk_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hw_r        <= hw_nxt;
      clr_addr_r  <= clr_addr_nxt;
      chk_addr_r  <= chk_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_req_r     <= op_req_nxt;
    res_page_r   <= res_page_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
  end

  bpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign back_stat.clearing = state_r == S_CLEAR;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({res_count_r, res_status_r, res_page_r});

endmodule

// ===== design/bitmap_page_allocator_top.sv =====
// read-check, rejected requests and write-mark below the count are answered from idle
// free and write-mark that sets a bit: read-modify-write of one map word
// allocate: scans map words from word 0 to the one holding the first free page,
// up to ceil(NUM_PAGES/64) words; back stage takes a new request only once the last is done
// reset: clearing pass over the ceil(NUM_PAGES/64) map ram words, in_tready low
// until it ends; pages 0 and 1 used and the count at 2 afterwards
module bitmap_page_allocator_top #(
  parameter int NUM_PAGES = bpa_pkg::DEF_NUM_PAGES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [1:0] command, [13:2] page_number
  input  logic [bpa_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [11:0] result_page, [13:12] status, [26:14] page_count_now
  output logic [bpa_pkg::OUT_DATA_W-1:0] out_tdata
);
  import bpa_pkg::*;

  back_stat_t back_stat;
  logic       fq_valid, fq_ready;
  req_t       fq_req;
  logic       qb_valid, qb_pop;
  req_t       qb_req;

  bpa_front #(
    .NUM_PAGES (NUM_PAGES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .back_stat (back_stat),
    .q_ready   (fq_ready),
    .q_push    (fq_valid),
    .q_req     (fq_req)
  );

  bpa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_req   (fq_req),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_pop),
    .pop_req    (qb_req)
  );

  bpa_back #(
    .NUM_PAGES (NUM_PAGES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_pop      (qb_pop),
    .q_req      (qb_req),
    .back_stat  (back_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== verif/bitmap_page_allocator_top_tb.sv =====
// testbench of the bitmap page allocator: directed, random, backpressure and fill tests
module bitmap_page_allocator_top_tb;
  import bpa_pkg::*;

  localparam int PAGES       = DEF_NUM_PAGES;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 4 + (PAGES + WORD_W - 1) / WORD_W + 16;
  localparam int REPLY_W     = COUNT_W + STATUS_W + PAGE_W;
  localparam int FILL_RUN    = 40;

  // same bit order as out_tdata: page lowest, then status, then count
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    status_t            status;
    logic [PAGE_W-1:0]  page;
  } alloc_reply_t;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_PATTERN,
    RX_SPARSE
  } rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // mirror of the allocator state
  bit           page_taken [PAGES];
  int           page_watermark;
  alloc_reply_t replies_due [$];
  alloc_reply_t got_reply;
  alloc_reply_t want_reply;

  int       mismatches;
  int       cycle_count;
  bit       sender_steady;
  int       burst_left;
  rx_mode_t rx_mode;
  int       rx_phase;
  int       hold_cycles;

  bitmap_page_allocator_top #(
    .NUM_PAGES(PAGES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_page_map();
    for (int i = 0; i < PAGES; i++) page_taken[i] = 1'b0;
    page_taken[0]  = 1'b1;
    page_taken[1]  = 1'b1;
    page_watermark = 2;
  endfunction

  function automatic alloc_reply_t predict_reply(cmd_t cmd, logic [PAGE_W-1:0] page);
    alloc_reply_t r;
    bit found;
    r.page   = page;
    r.status = ST_OK;
    found    = 1'b0;
    case (cmd)
      CMD_ALLOC: begin
        r.status = ST_FULL;
        r.page   = '0;
        // first fit from page 1 up, page 0 is never handed out
        for (int i = 1; i < PAGES && !found; i++) begin
          if (!page_taken[i]) begin
            found         = 1'b1;
            page_taken[i] = 1'b1;
            if (i >= page_watermark) page_watermark = i + 1;
            r.page   = i[PAGE_W-1:0];
            r.status = ST_OK;
          end
        end
      end
      CMD_FREE: begin
        if (page == 0 || int'(page) >= PAGES) r.status = ST_RANGE;
        else page_taken[page] = 1'b0;
      end
      CMD_MARK: begin
        if (int'(page) >= PAGES) begin
          r.status = ST_RANGE;
        end else if (int'(page) >= page_watermark) begin
          page_watermark   = page + 1;
          page_taken[page] = 1'b1;
        end
      end
      default: begin
        if (int'(page) >= page_watermark) r.status = ST_BEYOND;
      end
    endcase
    r.count = page_watermark[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [PAGE_W-1:0] page_near_mark();
    int p;
    p = page_watermark - 3 + int'($urandom_range(0, 6));
    if (p < 0) p = 0;
    if (p > PAGES - 1) p = PAGES - 1;
    return p[PAGE_W-1:0];
  endfunction

  function automatic logic [PAGE_W-1:0] page_below_mark();
    int lim;
    lim = (page_watermark < PAGES) ? page_watermark - 1 : PAGES - 1;
    return PAGE_W'($urandom_range(0, lim));
  endfunction

  // receiver: stalls on its own pattern, long hold-off counted here
  always @(negedge clk) begin
    rx_phase++;
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:    out_tready <= 1'b1;
        RX_RANDOM:  out_tready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_tready <= ((rx_phase % 7) < 4);
        default:    out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_reply = out_tdata[REPLY_W-1:0];
      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: reply with none pending: page %0d status %0d count %0d",
                 $time, got_reply.page, got_reply.status, got_reply.count);
      end else begin
        want_reply = replies_due.pop_front();
        if (got_reply !== want_reply) begin
          mismatches++;
          $display("%0t: expected page %0d status %0d count %0d, got page %0d status %0d count %0d",
                   $time, want_reply.page, want_reply.status, want_reply.count,
                   got_reply.page, got_reply.status, got_reply.count);
        end
      end
    end
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_req(input cmd_t cmd, input logic [PAGE_W-1:0] page);
    int gap;
    if (!sender_steady) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        repeat (gap) begin
          @(negedge clk);
          in_tvalid <= 1'b0;
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - CMD_W - PAGE_W){1'b0}}, page, cmd};
    do @(posedge clk); while (!in_tready);
    replies_due.push_back(predict_reply(cmd, page));
  endtask

  // sender pauses until every pending reply is back
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_req();
    int pick;
    logic [PAGE_W-1:0] page;
    pick = $urandom_range(0, 99);
    page = PAGE_W'($urandom);
    if (pick < 35) begin
      send_req(CMD_ALLOC, page);
    end else if (pick < 60) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) page = '0;
      else if (pick > 2) page = page_below_mark();
      send_req(CMD_FREE, page);
    end else if (pick < 75) begin
      // a rare fully random mark may jump the count far up
      if ($urandom_range(0, 49) != 0)
        page = $urandom_range(0, 1) ? page_near_mark() : page_below_mark();
      send_req(CMD_MARK, page);
    end else begin
      if ($urandom_range(0, 3) != 0) page = page_near_mark();
      send_req(CMD_CHECK, page);
    end
  endtask

  task automatic test_directed();
    sender_steady = 1'b1;
    rx_mode       = RX_OPEN;
    send_req(CMD_CHECK, 12'd0);
    send_req(CMD_CHECK, 12'd1);
    send_req(CMD_CHECK, 12'd2);
    send_req(CMD_CHECK, 12'hFFF);
    send_req(CMD_ALLOC, 12'hFFF);
    send_req(CMD_FREE, 12'd0);
    send_req(CMD_FREE, 12'd2);
    // freeing a clear page is still ok
    send_req(CMD_FREE, 12'd2);
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_MARK, 12'd1);
    send_req(CMD_MARK, 12'd100);
    send_req(CMD_CHECK, 12'd100);
    send_req(CMD_CHECK, 12'd101);
    send_req(CMD_MARK, 12'd101);
    send_req(CMD_ALLOC, 12'h555);
    send_req(CMD_FREE, 12'd1);
    send_req(CMD_ALLOC, 12'hAAA);
    send_req(CMD_CHECK, 12'd3);
    send_req(CMD_FREE, 12'hFFF);
    wait_idle();
  endtask

  task automatic test_random(input int n_reqs);
    for (int phase = 0; phase < 4; phase++) begin
      sender_steady = (phase == 0 || phase == 3);
      case (phase)
        0:       rx_mode = RX_OPEN;
        1:       rx_mode = RX_RANDOM;
        2:       rx_mode = RX_PATTERN;
        default: rx_mode = RX_SPARSE;
      endcase
      repeat (n_reqs / 4) send_random_req();
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    sender_steady = 1'b1;
    rx_mode       = RX_OPEN;
    @(posedge clk);
    hold_cycles = 400;
    repeat (40) send_random_req();
    wait_idle();
    sender_steady = 1'b0;
    rx_mode       = RX_RANDOM;
    repeat (20) send_random_req();
    wait_idle();
  endtask

  task automatic test_fill();
    int clear_pages;
    sender_steady = 1'b0;
    rx_mode       = RX_RANDOM;
    send_req(CMD_MARK, PAGE_W'(PAGES - 1));
    send_req(CMD_CHECK, PAGE_W'(PAGES - 1));
    clear_pages = 0;
    for (int i = 1; i < PAGES; i++) if (!page_taken[i]) clear_pages++;
    // take a run of the lowest clear pages
    if (clear_pages > FILL_RUN) clear_pages = FILL_RUN;
    repeat (clear_pages) send_req(CMD_ALLOC, PAGE_W'($urandom));
    send_req(CMD_ALLOC, 12'hFFF);
    send_req(CMD_FREE, 12'd0);
    send_req(CMD_FREE, PAGE_W'(PAGES - 1));
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_FREE, 12'd3);
    send_req(CMD_FREE, 12'd2000);
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_CHECK, PAGE_W'(PAGES - 1));
    wait_idle();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    hold_cycles   = 0;
    rx_phase      = 0;
    rx_mode       = RX_OPEN;
    sender_steady = 1'b1;
    burst_left    = 0;
    mismatches    = 0;
    cycle_count   = 0;
    reset_page_map();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(720);
    test_backpressure();
    test_fill();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
